// ===== sv/srld_pkg.sv =====
// Package with the word types and sizing constants of the sprite run-length decoder.
package srld_pkg;

    localparam int unsigned PIXEL_COUNT_DEF = 1024;
    localparam int unsigned INDEX_W         = 10;
    localparam int unsigned CONSUMED_W      = 18;
    localparam int unsigned COUNT_W         = 16;
    localparam int unsigned SUM_W           = COUNT_W + 1;
    localparam int unsigned KEY_SKIP        = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       record_start;
    } t_in_word;

    typedef struct packed {
        logic               pixel_valid;
        logic [INDEX_W-1:0] pixel_index;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               last;
    } t_out_word;

endpackage

// ===== sv/sprite_run_length_decoder.sv =====
// Sprite run-length decoder: byte-wide record parser that emits colored pixel words and finish words.
// A pixel or finish word is registered and appears on the output in the cycle after its byte is accepted.
// One byte is taken per cycle while o_stall is low; the phase register and counters update on each accepted byte.
// The output register drains while the next byte is accepted; stall passes upstream only
// when a held word is stalled. Synchronous active-low reset returns the parser to idle,
// clears all counters and empties the output register.
module sprite_run_length_decoder #(
    parameter int unsigned PIXEL_COUNT = srld_pkg::PIXEL_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  srld_pkg::t_in_word  i_data,
    output logic                o_stall,
    output logic                o_valid,
    output srld_pkg::t_out_word o_data,
    input  logic                i_stall
);

    localparam int unsigned WPW = $clog2(PIXEL_COUNT + 1);
    localparam logic [WPW-1:0] PC_W = WPW'(PIXEL_COUNT);
    localparam logic [srld_pkg::SUM_W-1:0] PC_S = srld_pkg::SUM_W'(PIXEL_COUNT);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_KEY      = 4'd1;
    localparam logic [3:0] PH_SIZE_LO  = 4'd2;
    localparam logic [3:0] PH_SIZE_HI  = 4'd3;
    localparam logic [3:0] PH_TRANS_LO = 4'd4;
    localparam logic [3:0] PH_TRANS_HI = 4'd5;
    localparam logic [3:0] PH_COL_LO   = 4'd6;
    localparam logic [3:0] PH_COL_HI   = 4'd7;
    localparam logic [3:0] PH_PIX_R    = 4'd8;
    localparam logic [3:0] PH_PIX_G    = 4'd9;
    localparam logic [3:0] PH_PIX_B    = 4'd10;
    localparam logic [3:0] PH_DONE     = 4'd11;

    logic [3:0]                        r_phase, n_phase;
    logic [1:0]                        r_key_left, n_key_left;
    logic [srld_pkg::COUNT_W-1:0]      r_size, n_size;
    logic [srld_pkg::CONSUMED_W-1:0]   r_consumed, n_consumed;
    logic [WPW-1:0]                    r_wp, n_wp;
    logic [7:0]                        r_low, n_low;
    logic [srld_pkg::COUNT_W-1:0]      r_col_left, n_col_left;
    logic [7:0]                        r_red, n_red;
    logic [7:0]                        r_green, n_green;
    logic                              r_out_valid;
    srld_pkg::t_out_word               r_out, n_out;
    logic                              n_has_out;
    logic                              accept;

    logic [7:0]                        b;
    logic [srld_pkg::COUNT_W-1:0]      word16;
    logic [srld_pkg::CONSUMED_W-1:0]   cons_inc;
    logic [srld_pkg::CONSUMED_W-1:0]   triple;
    logic [srld_pkg::SUM_W-1:0]        trans_sum;
    logic [WPW-1:0]                    wp_inc;
    logic [srld_pkg::COUNT_W-1:0]      col_dec;
    logic                              wp_full;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    assign b         = i_data.data_byte;
    assign word16    = {b, r_low};
    assign cons_inc  = r_consumed + srld_pkg::CONSUMED_W'(1);
    assign triple    = {1'b0, word16, 1'b0} + srld_pkg::CONSUMED_W'(word16);
    assign trans_sum = srld_pkg::SUM_W'(r_wp) + srld_pkg::SUM_W'(word16);
    assign wp_inc    = r_wp + WPW'(1);
    assign col_dec   = r_col_left - srld_pkg::COUNT_W'(1);
    assign wp_full   = (r_wp >= PC_W);

    always_comb begin
        n_phase    = r_phase;
        n_key_left = r_key_left;
        n_size     = r_size;
        n_consumed = r_consumed;
        n_wp       = r_wp;
        n_low      = r_low;
        n_col_left = r_col_left;
        n_red      = r_red;
        n_green    = r_green;
        n_has_out  = 1'b0;
        n_out      = '0;
        if (i_data.record_start) begin
            n_phase    = PH_KEY;
            n_key_left = 2'(srld_pkg::KEY_SKIP);
            n_size     = '0;
            n_consumed = '0;
            n_wp       = '0;
            n_low      = '0;
            n_col_left = '0;
            n_red      = '0;
            n_green    = '0;
        end else begin
            case (r_phase)
                PH_KEY: begin
                    n_key_left = r_key_left - 2'd1;
                    if (n_key_left == 2'd0) begin
                        n_phase = PH_SIZE_LO;
                    end
                end
                PH_SIZE_LO: begin
                    n_low   = b;
                    n_phase = PH_SIZE_HI;
                end
                PH_SIZE_HI: begin
                    n_size = word16;
                    if (word16 == '0 || wp_full) begin
                        n_phase   = PH_DONE;
                        n_has_out = 1'b1;
                        n_out.last = 1'b1;
                    end else begin
                        n_phase = PH_TRANS_LO;
                    end
                end
                PH_TRANS_LO: begin
                    n_consumed = cons_inc;
                    n_low      = b;
                    n_phase    = PH_TRANS_HI;
                end
                PH_TRANS_HI: begin
                    n_consumed = cons_inc;
                    n_wp       = (trans_sum > PC_S) ? PC_W : trans_sum[WPW-1:0];
                    n_phase    = PH_COL_LO;
                end
                PH_COL_LO: begin
                    n_consumed = cons_inc;
                    n_low      = b;
                    n_phase    = PH_COL_HI;
                end
                PH_COL_HI: begin
                    n_consumed = cons_inc;
                    if (word16 == '0 || wp_full) begin
                        n_col_left = '0;
                        if (cons_inc >= srld_pkg::CONSUMED_W'(r_size) || wp_full) begin
                            n_phase    = PH_DONE;
                            n_has_out  = 1'b1;
                            n_out.last = 1'b1;
                        end else begin
                            n_phase = PH_TRANS_LO;
                        end
                    end else begin
                        n_consumed = cons_inc + triple;
                        n_col_left = word16;
                        n_phase    = PH_PIX_R;
                    end
                end
                PH_PIX_R: begin
                    n_red   = b;
                    n_phase = PH_PIX_G;
                end
                PH_PIX_G: begin
                    n_green = b;
                    n_phase = PH_PIX_B;
                end
                PH_PIX_B: begin
                    n_wp              = wp_inc;
                    n_has_out         = 1'b1;
                    n_out.pixel_valid = 1'b1;
                    n_out.pixel_index = srld_pkg::INDEX_W'(r_wp);
                    n_out.red         = r_red;
                    n_out.green       = r_green;
                    n_out.blue        = b;
                    if (col_dec == '0 || wp_inc >= PC_W) begin
                        n_col_left = '0;
                        if (r_consumed >= srld_pkg::CONSUMED_W'(r_size)
                                || wp_inc >= PC_W) begin
                            n_phase    = PH_DONE;
                            n_out.last = 1'b1;
                        end else begin
                            n_phase = PH_TRANS_LO;
                        end
                    end else begin
                        n_col_left = col_dec;
                        n_phase    = PH_PIX_R;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_key_left  <= '0;
            r_size      <= '0;
            r_consumed  <= '0;
            r_wp        <= '0;
            r_low       <= '0;
            r_col_left  <= '0;
            r_red       <= '0;
            r_green     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_key_left  <= n_key_left;
                r_size      <= n_size;
                r_consumed  <= n_consumed;
                r_wp        <= n_wp;
                r_low       <= n_low;
                r_col_left  <= n_col_left;
                r_red       <= n_red;
                r_green     <= n_green;
                r_out_valid <= n_has_out;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_has_out) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_finish_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.pixel_valid |-> o_data.last)
        else $error("word without pixel is not a finish word");

    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= PC_W)
        else $error("write position beyond pixel count");

    a_pix_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIX_R || r_phase == PH_PIX_G || r_phase == PH_PIX_B)
        |-> (r_col_left != '0 && !wp_full))
        else $error("pixel phase with no pixels left");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled output word changed");

    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_phase == PH_DONE && !i_data.record_start |=> !o_valid)
        else $error("word emitted after finish");
`endif

endmodule
